FILE: hw/rtl/ovl_pkg.sv
// Shared sizes, codes and types for the ordered value list.
`timescale 1ns / 1ps
`default_nettype none

package ovl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int PTR_W    = CNT_W + 1;
  localparam int VAL_W    = 32;

  localparam logic [1:0] FN_APPEND = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_LOOKUP = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] pos;
    status_t          status;
    logic [CNT_W-1:0] cnt;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ordered_value_list_top.sv
// Top level of the ordered value list: sequencer, entry store, result port register.
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY (16) signed 32-bit values, oldest first.
// A transaction is accepted on a rising edge with start high and busy low.
// Append, an unused func code and a remove or lookup on an empty list finish
// at once: busy stays low and the next transaction may follow in the next
// cycle. Lookup walks the store one entry per cycle through the single
// compare unit until it hits or has compared the last entry. Remove searches
// the same way, then compacts the tail one entry per cycle through the
// store's single read and write port. The store's registered read means
// the compare sees each entry in the cycle after its address is driven.
// Each result is registered onto the result ports and marked by a one-cycle
// done pulse in the cycle after the sequencer finishes. The receiver cannot stall:
// sample the result on the edge that ends the done cycle or lose it.

module ordered_value_list_top
  import ovl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        func,
  input  wire logic signed [31:0] item_value,
  output logic                   done,
  output logic                   found,
  output logic [3:0]             match_position,
  output logic [1:0]             status,
  output logic [4:0]             entry_count
);

  mem_req_t         req;
  logic [VAL_W-1:0] rd_data;
  logic             res_vld;
  res_t             res;

  ovl_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .func       (func),
    .item_value (item_value),
    .rd_data    (rd_data),
    .req        (req),
    .busy       (busy),
    .res_vld    (res_vld),
    .res        (res)
  );

  ovl_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // Register each finished result onto the ports and pulse done; the field widths are
  // fixed, so narrow or widen the internal position and count to fit.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_vld;
    end
    if (res_vld) begin
      found          <= res.found;
      match_position <= 4'(res.pos);
      status         <= res.status;
      entry_count    <= 5'(res.cnt);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ovl_store.sv
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ovl_store
  import ovl_pkg::*;
(
  input  wire logic             clk,
  input  wire mem_req_t         req,
  output logic      [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ovl_seq.sv
// Sequencer: walks the store one entry a cycle for search and compaction.
`timescale 1ns / 1ps
`default_nettype none

module ovl_seq
  import ovl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [1:0]        func,
  input  wire logic signed [VAL_W-1:0] item_value,
  input  wire logic [VAL_W-1:0]  rd_data,
  output mem_req_t               req,
  output logic                   busy,
  output logic                   res_vld,
  output res_t                   res
);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_SHIFT} state_t;

  state_t           state;
  logic [1:0]       op;
  logic [VAL_W-1:0] value;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] ptr;
  logic [IDX_W-1:0] tag;
  logic             tag_vld;

  logic             full;
  logic             hit;
  logic             last;
  logic             ptr_in;
  logic             app_ok;

  assign busy   = (state != S_IDLE);
  assign full   = (count >= CNT_W'(CAPACITY));
  assign hit    = tag_vld && (rd_data == value);
  assign last   = ((CNT_W'(tag) + CNT_W'(1)) == count);
  assign ptr_in = (ptr < PTR_W'(count));
  assign app_ok = (state == S_IDLE) && start && (func == FN_APPEND) && !full;

  always_comb begin
    req.raddr = ptr[IDX_W-1:0];
    if (state == S_IDLE) begin
      req.we    = app_ok;
      req.waddr = count[IDX_W-1:0];
      req.wdata = item_value;
    end else begin
      // compaction: data read from tag moves down one place
      req.we    = (state == S_SHIFT) && tag_vld;
      req.waddr = IDX_W'(tag - IDX_W'(1));
      req.wdata = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      res_vld <= 1'b0;
      tag_vld <= 1'b0;
    end else begin
      res_vld <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op      <= func;
            value   <= item_value;
            ptr     <= '0;
            tag_vld <= 1'b0;
            res.found <= 1'b0;
            res.pos   <= '0;
            case (func) inside
              FN_APPEND: begin
                res.status <= full ? ST_FULL : ST_OK;
                res.cnt    <= full ? count : CNT_W'(count + CNT_W'(1));
                if (!full) begin
                  count <= CNT_W'(count + CNT_W'(1));
                end
                res_vld <= 1'b1;
              end
              FN_REMOVE, FN_LOOKUP: begin
                if (count == '0) begin
                  res.status <= ST_NOTFOUND;
                  res.cnt    <= count;
                  res_vld    <= 1'b1;
                end else begin
                  state <= S_SEARCH;
                end
              end
              default: begin
                res.status <= ST_OK;
                res.cnt    <= count;
                res_vld    <= 1'b1;
              end
            endcase
          end
        end
        S_SEARCH: begin
          tag     <= ptr[IDX_W-1:0];
          tag_vld <= ptr_in;
          ptr     <= PTR_W'(ptr + PTR_W'(1));
          if (hit) begin
            res.found  <= 1'b1;
            res.pos    <= tag;
            res.status <= ST_OK;
            if (op == FN_REMOVE) begin
              res.cnt <= CNT_W'(count - CNT_W'(1));
              ptr     <= PTR_W'(PTR_W'(tag) + PTR_W'(1));
              tag_vld <= 1'b0;
              state   <= S_SHIFT;
            end else begin
              res.cnt <= count;
              res_vld <= 1'b1;
              state   <= S_IDLE;
            end
          end else if (tag_vld && last) begin
            res.found  <= 1'b0;
            res.pos    <= '0;
            res.status <= ST_NOTFOUND;
            res.cnt    <= count;
            res_vld    <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_SHIFT: begin
          tag     <= ptr[IDX_W-1:0];
          tag_vld <= ptr_in;
          ptr     <= PTR_W'(ptr + PTR_W'(1));
          if (!ptr_in && !tag_vld) begin
            count   <= CNT_W'(count - CNT_W'(1));
            res_vld <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    res_vld && res.found |-> res.status == ST_OK)
    else $error("found result without ok status");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> count != '0)
    else $error("compaction on an empty list");

  a_no_write_search: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> !req.we)
    else $error("store written during search");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res_vld |-> (res.cnt == count) && (count <= CNT_W'(CAPACITY)))
    else $error("result count disagrees with list count");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the ordered value list: directed and random list operations.
`timescale 1ns / 1ps

module testbench;
  import ovl_pkg::*;

  // Spare operation code; the block must treat it as a no-op with status ok.
  localparam logic [1:0] FN_UNUSED   = 2'd3;
  localparam int         RANDOM_OPS  = 1700;
  // Worst case per transaction: the largest idle gap, the longest remove and the result lag.
  // CYCLE_LIMIT leaves more than five times the slowest correct run.
  localparam int         CYCLE_LIMIT = 400000;

  // One queued list command for the driver.
  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] value;
    int                 gap;   // idle cycles before the command is offered
    bit                 hold;  // wait for every pending result before offering
  } list_cmd_t;

  logic              clk;
  logic              rst   = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        func  = FN_APPEND;
  logic signed [31:0] item_value = '0;
  logic              busy;
  logic              done;
  logic              found;
  logic [3:0]        match_position;
  logic [1:0]        status;
  logic [4:0]        entry_count;

  list_cmd_t          cmd_queue[$];
  res_t               expected_results[$];
  logic signed [31:0] list_contents[$];   // shadow of the stored list, head first
  logic signed [31:0] value_pool[8];      // small pool so searches hit often

  list_cmd_t cur_cmd;
  bit        cmd_loaded  = 1'b0;
  int        gap_left    = 0;
  bit        xfer_taken  = 1'b0;
  bit        no_idle     = 1'b0;
  int        mismatch_count = 0;
  int        cycle_count    = 0;

  ordered_value_list_top u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .item_value     (item_value),
    .done           (done),
    .found          (found),
    .match_position (match_position),
    .status         (status),
    .entry_count    (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow list and return the result it owes.
  // Append fills the tail or reports full; remove deletes the first match
  // and lets later entries close the gap; lookup only reports the first
  // match. A miss, including any search of an empty list, leaves the list
  // alone. The spare code changes nothing and reports ok.
  function automatic res_t apply_list_op(logic [1:0] op, logic signed [31:0] v);
    res_t r;
    int   hit;
    int   i;
    r.found  = 1'b0;
    r.pos    = '0;
    r.status = ST_OK;
    hit      = -1;
    if (op == FN_APPEND) begin
      if (list_contents.size() < CAPACITY) list_contents.push_back(v);
      else r.status = ST_FULL;
    end else if (op == FN_REMOVE || op == FN_LOOKUP) begin
      for (i = 0; i < list_contents.size(); i++) begin
        if (hit < 0 && list_contents[i] == v) hit = i;
      end
      if (hit < 0) begin
        r.status = ST_NOTFOUND;
      end else begin
        r.found = 1'b1;
        r.pos   = hit[IDX_W-1:0];
        if (op == FN_REMOVE) list_contents.delete(hit);
      end
    end
    // Count is cut to CNT_W, which always holds CAPACITY.
    r.cnt = CNT_W'(list_contents.size());
    return r;
  endfunction

  // Mostly pool values so removes and lookups find something; the rest are
  // fully random so every data bit toggles.
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return value_pool[$urandom_range(0, 7)];
  endfunction

  task automatic add_cmd(logic [1:0] op, logic signed [31:0] v, bit hold);
    list_cmd_t c;
    c.op    = op;
    c.value = v;
    c.gap   = no_idle ? 0 : $urandom_range(0, 9);
    c.hold  = hold;
    cmd_queue.push_back(c);
  endtask

  // Driver: change inputs on the falling edge only. A transaction leaves
  // the port once the monitor saw it accepted; the next one follows after
  // its idle gap, back to back when the gap is zero. start gets exactly one
  // assignment per edge so a held-high start never glitches.
  always @(negedge clk) begin
    logic raise;
    raise = start;
    if (rst) begin
      raise = 1'b0;
    end else begin
      if (start && xfer_taken) raise = 1'b0;
      if (!raise) begin
        if (!cmd_loaded && cmd_queue.size() > 0) begin
          cur_cmd    = cmd_queue.pop_front();
          cmd_loaded = 1'b1;
          gap_left   = cur_cmd.gap;
        end
        if (cmd_loaded) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!cur_cmd.hold || expected_results.size() == 0) begin
            func       <= cur_cmd.op;
            item_value <= cur_cmd.value;
            raise      = 1'b1;
            cmd_loaded = 1'b0;
          end
        end
      end
    end
    start <= raise;
  end

  // Monitor: on each rising edge, check a strobed result against the oldest
  // expectation, then log an accepted transaction and predict its result.
  // Checking comes first so a result and a new acceptance on the same edge
  // never see each other's entry.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      xfer_taken <= 1'b0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result strobed with no transaction outstanding");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            mismatch_count++;
          end
          if (match_position !== want.pos) begin
            $error("match_position: expected %0d, got %0d", want.pos, match_position);
            mismatch_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatch_count++;
          end
          if (entry_count !== want.cnt) begin
            $error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
            mismatch_count++;
          end
        end
      end
      xfer_taken <= start && !busy;
      if (start && !busy) expected_results.push_back(apply_list_op(func, item_value));
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    int roll;
    bit drain_phase;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    value_pool[5] = $urandom;
    value_pool[6] = $urandom;
    value_pool[7] = $urandom;

    // Directed: searches and the spare code on an empty list, then fill to
    // capacity with extremes and a duplicate, overflow once, and hit the
    // head, the last slot and a duplicate's first copy.
    add_cmd(FN_LOOKUP, 0, 1'b0);
    add_cmd(FN_REMOVE, 5, 1'b0);
    add_cmd(FN_UNUSED, -1, 1'b0);
    add_cmd(FN_APPEND, 32'sh8000_0000, 1'b0);
    add_cmd(FN_APPEND, 32'sh7fff_ffff, 1'b0);
    add_cmd(FN_APPEND, 0, 1'b0);
    add_cmd(FN_APPEND, -1, 1'b0);
    add_cmd(FN_APPEND, 32'sh7fff_ffff, 1'b0);
    for (n = 0; n < 11; n++) add_cmd(FN_APPEND, 100 + n, 1'b0);
    add_cmd(FN_APPEND, 111, 1'b0);                // list full
    add_cmd(FN_LOOKUP, 110, 1'b0);                // last slot
    add_cmd(FN_REMOVE, 32'sh7fff_ffff, 1'b0);     // first of two copies
    add_cmd(FN_REMOVE, 110, 1'b0);                // tail
    add_cmd(FN_REMOVE, 32'sh8000_0000, 1'b0);     // head
    add_cmd(FN_LOOKUP, 12345, 1'b0);              // miss
    add_cmd(FN_LOOKUP, 32'sh7fff_ffff, 1'b0);     // surviving copy moved up

    // Random: alternate fill-leaning and drain-leaning stretches so the list
    // swings between empty and full; toggle no-idle bursts and wait for every
    // pending result now and then.
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      drain_phase = (((n / 64) % 2) != 0);
      roll = $urandom_range(0, 99);
      if (roll < 3)
        add_cmd(FN_UNUSED, pick_value(), n % 250 == 0);
      else if (roll < (drain_phase ? 28 : 60))
        add_cmd(FN_APPEND, pick_value(), n % 250 == 0);
      else if (roll < (drain_phase ? 75 : 85))
        add_cmd(FN_REMOVE, pick_value(), n % 250 == 0);
      else
        add_cmd(FN_LOOKUP, pick_value(), n % 250 == 0);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the last transaction to leave the port, then for its result,
    // then longer still to catch any stray strobe.
    while (cmd_queue.size() != 0 || cmd_loaded || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ovl_pkg.sv
hw/rtl/ovl_store.sv
hw/rtl/ovl_seq.sv
hw/rtl/ordered_value_list_top.sv
dv/testbench.sv
